@@ src/dstq_pkg.sv @@
// dstq_pkg: shared constants, codes and types for the deadline sorted timer queue
// no dependencies
`timescale 1ns / 1ps
package dstq_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int CAPACITY    = (QUEUE_DEPTH < 16) ? QUEUE_DEPTH : 16;
  localparam int PW          = $clog2(CAPACITY);
  localparam int CW          = $clog2(CAPACITY + 1);

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_EXPIRE = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_NOTHING   = 2'd3;

  localparam logic [1:0] REG_HALVE  = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_FREEZE = 2'd2;

  typedef struct packed {
    logic [31:0] deadline;
    logic [15:0] routine;
    logic [3:0]  hnd;
  } entry_t;

  // memory port request from the sequencer
  typedef struct packed {
    logic          rd_en;
    logic [PW-1:0] rd_addr;
    logic          wr_en;
    logic [PW-1:0] wr_addr;
    entry_t        wr_data;
  } mem_req_t;
endpackage

@@ src/dstq_mem.sv @@
// dstq_mem: entry store, one write and one registered read port
// depends on dstq_pkg
`timescale 1ns / 1ps
module dstq_mem (
  input  logic                clk,
  input  dstq_pkg::mem_req_t  req,
  output dstq_pkg::entry_t    rd_data
);
  dstq_pkg::entry_t mem [dstq_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.wr_en) mem[req.wr_addr] <= req.wr_data;
    if (req.rd_en) rd_data <= mem[req.rd_addr];
  end
endmodule

@@ src/dstq_ctrl.sv @@
// dstq_ctrl: command sequencer, walks the entry memory for insert, delete, expire
// depends on dstq_pkg, drives dstq_mem
`timescale 1ns / 1ps
module dstq_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_halve,
  input  logic [31:0]                cfg_offset,
  input  logic                       cfg_freeze,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 mode,
  input  logic [31:0]                now_time,
  input  logic [31:0]                hold_started_at,
  input  logic [15:0]                timeout,
  input  logic [15:0]                routine_id,
  input  logic [3:0]                 handle,
  output dstq_pkg::mem_req_t         req,
  input  dstq_pkg::entry_t           rd_data,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [1:0]                 res_status,
  output logic [15:0]                res_id,
  output logic                       res_fired,
  output logic [3:0]                 res_handle,
  output logic                       res_last
);
  localparam int PW = dstq_pkg::PW;
  localparam int CW = dstq_pkg::CW;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_FIND  = 12'b000000000010,  // read entry idx while scanning
    S_FCHK  = 12'b000000000100,  // compare entry idx
    S_SHUP  = 12'b000000001000,  // read idx-1, or place the new entry at pos
    S_SHUPW = 12'b000000010000,  // copy entry idx-1 to idx
    S_SHDN  = 12'b000000100000,  // read idx, or finish the removal
    S_SHDNW = 12'b000001000000,  // copy entry idx to idx-1
    S_EXP   = 12'b000010000000,  // read head entry
    S_ECHK  = 12'b000100000000,  // test head entry
    S_EMIT  = 12'b001000000000,  // report the previous popped entry, not final
    S_POP   = 12'b010000000000,  // take head entry out
    S_OUT   = 12'b100000000000   // final beat of the command
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic [dstq_pkg::CAPACITY-1:0] in_use;
  logic [1:0]  op;
  logic [31:0] dl;
  logic [31:0] adj;
  logic [15:0] rid;
  logic [3:0]  hnd;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_m1;
  logic [CW-1:0] pos;
  logic        have_pend;
  logic [15:0] pend_id;
  dstq_pkg::entry_t head_r;
  logic [1:0]  st_r;
  logic [15:0] id_r;
  logic        fired_r;
  logic [3:0]  nh_r;
  logic        beat_go;

  // lowest free handle
  logic [PW-1:0] free_h;
  logic          free_ok;
  always_comb begin
    free_h = '0;
    free_ok = 1'b0;
    for (int h = dstq_pkg::CAPACITY - 1; h >= 0; h--) begin
      if (!in_use[h]) begin
        free_h = PW'(h);
        free_ok = 1'b1;
      end
    end
  end

  logic [31:0] tmo_eff, dl_calc;
  logic        held;
  assign held    = cfg_freeze && (hold_started_at != 32'd0);
  assign tmo_eff = cfg_halve ? {17'd0, timeout[15:1]} : {16'd0, timeout};
  assign dl_calc = held ? (hold_started_at + tmo_eff - cfg_offset)
                        : (now_time + tmo_eff - cfg_offset);

  assign in_ready = (state == S_IDLE) && !res_valid;
  assign idx_m1   = idx - 1'b1;
  assign beat_go  = (state == S_OUT || state == S_EMIT) && (!res_valid || res_ready);

  // memory requests; read data comes back through the registered read port
  always_comb begin
    req.rd_en   = 1'b0;
    req.rd_addr = idx[PW-1:0];
    req.wr_en   = 1'b0;
    req.wr_addr = idx[PW-1:0];
    req.wr_data = rd_data;
    unique case (state)
      S_FIND: req.rd_en = (idx < count);
      S_SHUP: begin
        if (idx == pos) begin
          req.wr_en   = 1'b1;
          req.wr_addr = pos[PW-1:0];
          req.wr_data = '{deadline: dl, routine: rid, hnd: hnd};
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = idx_m1[PW-1:0];
        end
      end
      S_SHUPW: req.wr_en = 1'b1;
      S_SHDN:  req.rd_en = (idx < count);
      S_SHDNW: begin
        req.wr_en   = 1'b1;
        req.wr_addr = idx_m1[PW-1:0];
      end
      S_EXP: begin
        req.rd_en   = (count != '0);
        req.rd_addr = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      in_use    <= '0;
      have_pend <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op  <= mode;
            dl  <= dl_calc;
            adj <= now_time - cfg_offset;
            rid <= routine_id;
            hnd <= (mode == dstq_pkg::MODE_INSERT) ? 4'(free_h) : handle;
            idx <= '0;
            have_pend <= 1'b0;
            id_r <= '0;
            fired_r <= 1'b0;
            nh_r <= '0;
            unique case (mode)
              dstq_pkg::MODE_INSERT: begin
                if (count >= CW'(dstq_pkg::CAPACITY) || !free_ok) begin
                  st_r <= dstq_pkg::ST_FULL;
                  state <= S_OUT;
                end else begin
                  st_r <= dstq_pkg::ST_OK;
                  state <= S_FIND;
                end
              end
              dstq_pkg::MODE_DELETE: begin
                if ({1'b0, handle} >= 5'(dstq_pkg::CAPACITY) ||
                    !in_use[PW'(handle)]) begin
                  st_r <= dstq_pkg::ST_NOT_FOUND;
                  state <= S_OUT;
                end else begin
                  st_r <= dstq_pkg::ST_OK;
                  in_use[PW'(handle)] <= 1'b0;
                  state <= S_FIND;
                end
              end
              dstq_pkg::MODE_EXPIRE: begin
                // nothing due unless an entry pops
                st_r <= dstq_pkg::ST_NOTHING;
                state <= held ? S_OUT : S_EXP;
              end
              default: begin
                st_r <= dstq_pkg::ST_OK;
                count <= '0;
                in_use <= '0;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_FIND: begin
          if (idx >= count) begin
            if (op == dstq_pkg::MODE_INSERT) begin
              pos <= idx;
              state <= S_SHUP;
            end else begin
              state <= S_OUT; // handle not stored
            end
          end else begin
            state <= S_FCHK;
          end
        end
        S_FCHK: begin
          if (op == dstq_pkg::MODE_INSERT) begin
            // new entry goes ahead of equal deadlines
            if (dl <= rd_data.deadline) begin
              pos <= idx;
              idx <= count;
              state <= S_SHUP;
            end else begin
              idx <= idx + 1'b1;
              state <= S_FIND;
            end
          end else if (rd_data.hnd == hnd) begin
            idx <= idx + 1'b1;
            state <= S_SHDN;
          end else begin
            idx <= idx + 1'b1;
            state <= S_FIND;
          end
        end
        S_SHUP: begin
          if (idx == pos) begin
            count <= count + 1'b1;
            in_use[PW'(hnd)] <= 1'b1;
            nh_r <= hnd;
            state <= S_OUT;
          end else begin
            state <= S_SHUPW;
          end
        end
        S_SHUPW: begin
          idx <= idx_m1;
          state <= S_SHUP;
        end
        S_SHDN: begin
          if (idx >= count) begin
            count <= count - 1'b1;
            state <= (op == dstq_pkg::MODE_EXPIRE) ? S_EXP : S_OUT;
          end else begin
            state <= S_SHDNW;
          end
        end
        S_SHDNW: begin
          idx <= idx + 1'b1;
          state <= S_SHDN;
        end
        S_EXP: begin
          if (count == '0) begin
            if (have_pend) begin
              st_r <= dstq_pkg::ST_OK;
              id_r <= pend_id;
              fired_r <= 1'b1;
            end
            state <= S_OUT;
          end else begin
            state <= S_ECHK;
          end
        end
        S_ECHK: begin
          if (rd_data.deadline <= adj) begin
            head_r <= rd_data;
            state <= have_pend ? S_EMIT : S_POP;
          end else begin
            // the entry popped last is the final beat
            if (have_pend) begin
              st_r <= dstq_pkg::ST_OK;
              id_r <= pend_id;
              fired_r <= 1'b1;
            end
            state <= S_OUT;
          end
        end
        S_EMIT: begin
          if (beat_go) state <= S_POP;
        end
        S_POP: begin
          pend_id <= head_r.routine;
          have_pend <= 1'b1;
          in_use[PW'(head_r.hnd)] <= 1'b0;
          idx <= CW'(1);
          state <= S_SHDN;
        end
        S_OUT: begin
          if (beat_go) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (beat_go) begin
      res_valid <= 1'b1;
      if (state == S_EMIT) begin
        res_status <= dstq_pkg::ST_OK;
        res_id     <= pend_id;
        res_fired  <= 1'b1;
        res_handle <= '0;
        res_last   <= 1'b0;
      end else begin
        res_status <= st_r;
        res_id     <= id_r;
        res_fired  <= fired_r;
        res_handle <= nh_r;
        res_last   <= 1'b1;
      end
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end
endmodule

@@ src/deadline_sorted_timer_queue.sv @@
// deadline_sorted_timer_queue: top level, config registers, memory and sequencer
// depends on dstq_pkg, dstq_mem, dstq_ctrl
//
//  channel | direction | signals
//  cfg     | in        | cfg_we, cfg_index, cfg_data
//  in      | in        | in_valid/in_ready, mode, now_time, hold_started_at,
//          |           | timeout, routine_id, handle
//  out     | out       | out_valid/out_ready, status, fired_id, fired,
//          |           | new_handle, last
//
// one command at a time; every memory read is a request followed by registered data
// insert and delete: scan entries for the slot or the handle, then move entries up or
// down to open or close the gap
// expire: reads the head and, per pop, reports the previous pop and moves entries down
// rst is synchronous; it empties the queue and clears the registers
// a stalled out beat holds the sequencer, the input is taken only when idle
`timescale 1ns / 1ps
module deadline_sorted_timer_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [31:0] now_time,
  input  logic [31:0] hold_started_at,
  input  logic [15:0] timeout,
  input  logic [15:0] routine_id,
  input  logic [3:0]  handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] fired_id,
  output logic        fired,
  output logic [3:0]  new_handle,
  output logic        last
);
  logic        halve_timeout;
  logic [31:0] stopped_clock_offset;
  logic        freeze_enable;
  dstq_pkg::mem_req_t req;
  dstq_pkg::entry_t   rd_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      halve_timeout <= 1'b0;
      stopped_clock_offset <= '0;
      freeze_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dstq_pkg::REG_HALVE:  halve_timeout <= cfg_data[0];
        dstq_pkg::REG_OFFSET: stopped_clock_offset <= cfg_data;
        dstq_pkg::REG_FREEZE: freeze_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dstq_mem u_mem (.clk(clk), .req(req), .rd_data(rd_data));

  dstq_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .cfg_halve(halve_timeout), .cfg_offset(stopped_clock_offset),
    .cfg_freeze(freeze_enable),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .now_time(now_time),
    .hold_started_at(hold_started_at), .timeout(timeout),
    .routine_id(routine_id), .handle(handle),
    .req(req), .rd_data(rd_data),
    .res_valid(out_valid), .res_ready(out_ready), .res_status(status),
    .res_id(fired_id), .res_fired(fired), .res_handle(new_handle), .res_last(last)
  );
endmodule

@@ src/dstq_checker.sv @@
// dstq_checker: port-level checks on the timer queue, bound to the top level
// depends on dstq_pkg
`timescale 1ns / 1ps
module dstq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic        fired,
  input logic        last,
  input logic [3:0]  new_handle,
  input logic [15:0] fired_id
);
  // a fired beat is always status ok
  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && fired |-> status == dstq_pkg::ST_OK) else $error("fired not ok");
  // error beats are final
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != dstq_pkg::ST_OK |-> last) else $error("error not last");
  // no new input taken while a beat waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while output pending");
  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fired_id) && $stable(new_handle))
    else $error("output changed under stall");
endmodule

bind deadline_sorted_timer_queue dstq_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status), .fired(fired),
  .last(last), .new_handle(new_handle), .fired_id(fired_id)
);
